@@ rtl/core/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

    // Fixed field widths of the sample path and result item
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 5;
    localparam int PHASE_BITS  = 4;
    localparam int OFFSET_BITS = 4;
    localparam int STRIDE_BITS = 5;
    localparam int WLEN_BITS   = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WLEN   = 2'd2;

    // Register reset values
    localparam logic [OFFSET_BITS-1:0] RST_OFFSET = 4'd0;
    localparam logic [STRIDE_BITS-1:0] RST_STRIDE = 5'd6;
    localparam logic [WLEN_BITS-1:0]   RST_WLEN   = 5'd5;

    // Largest phase span the phase counter covers
    localparam logic [STRIDE_BITS-1:0] STRIDE_MAX = 5'd16;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   frame_last;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] median;
        logic [COUNT_BITS-1:0]  used_count;
        logic                   short_frame;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic take;    // an input item is accepted this cycle
        logic shift;   // move the sorted row down one place
        logic emit;    // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic shift_done;
    } t_dp_sts;

    typedef enum logic {
        ST_COLLECT,
        ST_MEDIAN
    } t_state;

endpackage

@@ rtl/core/strided_window_median_top.sv @@
`timescale 1ns / 1ps
// Non-final samples: one item per cycle.
// Frame end: after the item marked frame_last is accepted (n = kept samples), the sorted
// row shifts down one place per cycle, floor((n-1)/2) places in all, to bring the middle
// entries to its head; the result register is loaded once the previous result is taken.
// Input is stalled from frame end until the result register is loaded.
// Reset (synchronous, active low) restores the registers and clears phase and count.

module strided_window_median_top #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  swm_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output swm_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    swm_pkg::t_dp_cmd cmd;
    swm_pkg::t_dp_sts sts;
    logic             cfg_we;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_item.frame_last),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    swm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_item      (o_out_item)
    );

endmodule

@@ rtl/core/swm_ctrl.sv @@
`timescale 1ns / 1ps

module swm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_stall,
    input  swm_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output swm_pkg::t_dp_cmd o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;
    logic            take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != swm_pkg::ST_COLLECT);
    assign take       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            swm_pkg::ST_COLLECT: begin
                o_cmd.take = take;
                if (take && i_in_last) begin
                    n_state = swm_pkg::ST_MEDIAN;
                end
            end
            swm_pkg::ST_MEDIAN: begin
                if (!i_sts.shift_done) begin
                    o_cmd.shift = 1'b1;
                end else if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = swm_pkg::ST_COLLECT;
                end
            end
            default: begin
                n_state = swm_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

@@ rtl/core/swm_dp.sv @@
`timescale 1ns / 1ps

module swm_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  swm_pkg::t_in_item                   i_item,
    input  swm_pkg::t_dp_cmd                    i_cmd,
    output swm_pkg::t_dp_sts                    o_sts,
    output swm_pkg::t_out_item                  o_item
);

    // Kept count never exceeds what the window length register can hold
    localparam int WIN_CAP_INT = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;
    localparam logic [swm_pkg::WLEN_BITS-1:0] WIN_CAP = swm_pkg::WLEN_BITS'(WIN_CAP_INT);
    localparam int IDX1 = (MAX_WINDOW > 1) ? 1 : 0;
    localparam int SHIFT_BITS = swm_pkg::COUNT_BITS - 1;

    logic [swm_pkg::OFFSET_BITS-1:0] r_offset;
    logic [swm_pkg::STRIDE_BITS-1:0] r_stride;
    logic [swm_pkg::WLEN_BITS-1:0]   r_wlen;

    logic [swm_pkg::SAMPLE_BITS-1:0] r_cell [MAX_WINDOW];
    logic [swm_pkg::SAMPLE_BITS-1:0] n_cell [MAX_WINDOW];
    logic [swm_pkg::COUNT_BITS-1:0]  r_kept;
    logic [swm_pkg::COUNT_BITS-1:0]  n_kept;
    logic [swm_pkg::PHASE_BITS-1:0]  r_phase;
    logic [swm_pkg::PHASE_BITS-1:0]  n_phase;
    logic [SHIFT_BITS-1:0]           r_shift_cnt;
    logic [swm_pkg::COUNT_BITS-1:0]  r_n;
    logic                            r_short;
    swm_pkg::t_out_item              r_out;

    logic [swm_pkg::STRIDE_BITS-1:0] eff_stride;
    logic [swm_pkg::WLEN_BITS-1:0]   eff_win;
    logic                            keep;
    logic [swm_pkg::COUNT_BITS-1:0]  n_minus1;
    logic [swm_pkg::SAMPLE_BITS:0]   pair_sum;
    logic [swm_pkg::SAMPLE_BITS-1:0] median;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= swm_pkg::RST_OFFSET;
            r_stride <= swm_pkg::RST_STRIDE;
            r_wlen   <= swm_pkg::RST_WLEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swm_pkg::CFG_OFFSET: r_offset <= i_cfg_data[swm_pkg::OFFSET_BITS-1:0];
                swm_pkg::CFG_STRIDE: r_stride <= i_cfg_data;
                swm_pkg::CFG_WLEN:   r_wlen   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp stride and window length to their usable ranges
    always_comb begin
        if (r_stride == '0) begin
            eff_stride = swm_pkg::STRIDE_BITS'(1);
        end else if (r_stride > swm_pkg::STRIDE_MAX) begin
            eff_stride = swm_pkg::STRIDE_MAX;
        end else begin
            eff_stride = r_stride;
        end
        if (r_wlen == '0) begin
            eff_win = swm_pkg::WLEN_BITS'(1);
        end else if (r_wlen > WIN_CAP) begin
            eff_win = WIN_CAP;
        end else begin
            eff_win = r_wlen;
        end
    end

    assign keep = (r_phase == r_offset) && (r_kept < eff_win);

    // Advance the scan phase, wrapping at the stride
    always_comb begin
        if ({1'b0, r_phase} + swm_pkg::STRIDE_BITS'(1) >= eff_stride) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + swm_pkg::PHASE_BITS'(1);
        end
    end

    // Sorted insertion, larger cells moving up; on shift, the row moves down one place
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.take && keep) begin
                if ((int'(r_kept) == i) ||
                    ((int'(r_kept) > i) && (r_cell[i] > i_item.sample))) begin
                    if (i == 0) begin
                        n_cell[i] = i_item.sample;
                    end else if (r_cell[(i == 0) ? 0 : i-1] > i_item.sample) begin
                        n_cell[i] = r_cell[(i == 0) ? 0 : i-1];
                    end else begin
                        n_cell[i] = i_item.sample;
                    end
                end
            end else if (i_cmd.shift) begin
                if (i < MAX_WINDOW - 1) begin
                    n_cell[i] = r_cell[(i < MAX_WINDOW - 1) ? i+1 : i];
                end
            end
        end
    end

    assign n_kept   = (keep) ? r_kept + swm_pkg::COUNT_BITS'(1) : r_kept;
    assign n_minus1 = n_kept - swm_pkg::COUNT_BITS'(1);

    // Sorted row, counters and frame-end snapshot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (!i_rst_n) begin
            r_kept      <= '0;
            r_phase     <= '0;
            r_shift_cnt <= '0;
        end else if (i_cmd.take) begin
            if (i_item.frame_last) begin
                r_kept      <= '0;
                r_phase     <= '0;
                r_shift_cnt <= (n_kept == '0) ? '0 : n_minus1[swm_pkg::COUNT_BITS-1:1];
            end else begin
                r_kept  <= n_kept;
                r_phase <= n_phase;
            end
        end else if (i_cmd.shift) begin
            r_shift_cnt <= r_shift_cnt - SHIFT_BITS'(1);
        end
    end

    // Hold count and short flag of the finished frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_item.frame_last) begin
            r_n     <= n_kept;
            r_short <= (n_kept < eff_win);
        end
    end

    assign o_sts.shift_done = (r_shift_cnt == '0);

    // Pick the middle value, the floor mean of the middle pair, or zero for an empty frame
    assign pair_sum = {1'b0, r_cell[0]} + {1'b0, r_cell[IDX1]};
    always_comb begin
        if (r_n == '0) begin
            median = '0;
        end else if (r_n[0]) begin
            median = r_cell[0];
        end else begin
            median = pair_sum[swm_pkg::SAMPLE_BITS:1];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.median      <= median;
            r_out.used_count  <= r_n;
            r_out.short_frame <= r_short;
        end
    end

    assign o_item = r_out;

endmodule

@@ rtl/core/swm_chk.sv @@
`timescale 1ns / 1ps

module swm_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input swm_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input swm_pkg::t_out_item o_out_item
);

    // A stalled result item stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // An empty frame reports zero median and a short frame
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.used_count == '0) |->
            o_out_item.short_frame && (o_out_item.median == '0))
        else $error("empty frame result malformed");

    // A full window never has zero samples
    a_full_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.short_frame |-> (o_out_item.used_count != '0))
        else $error("full window with no samples");

    // The block is busy right after a frame ends
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.frame_last |=> o_in_stall)
        else $error("item accepted during median readout");

endmodule

bind strided_window_median_top swm_chk u_swm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
